>>> sv/kmm_pkg.sv
package kmm_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int NAME_BYTES  = 64;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int FILL_W      = SLOT_W + 1;
    localparam int POS_W       = $clog2(NAME_BYTES);
    localparam int NADDR_W     = SLOT_W + POS_W;

    localparam logic [7:0] SEP_CHAR = 8'h3B;
    localparam logic [7:0] EOL_CHAR = 8'h0A;

    localparam logic [1:0] OP_TEXT  = 2'd0;
    localparam logic [1:0] OP_STATS = 2'd1;
    localparam logic [1:0] OP_NAME  = 2'd2;

    localparam logic [1:0] KIND_APPLIED = 2'd0;
    localparam logic [1:0] KIND_STATS   = 2'd1;
    localparam logic [1:0] KIND_NAME    = 2'd2;
    localparam logic [1:0] KIND_DROPPED = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0]    len;
        logic signed [10:0]  min;
        logic signed [10:0]  max;
        logic signed [47:0]  sum;
        logic [31:0]         count;
    } entry_t;

    typedef struct packed {
        logic                phase;
        logic [POS_W-1:0]    len;
        logic                trunc;
        logic                seen;
        logic signed [10:0]  temp;
    } line_info_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic [7:0]          slot;
        logic                is_new;
        logic signed [10:0]  min;
        logic signed [10:0]  max;
        logic signed [47:0]  sum;
        logic [31:0]         count;
        logic [7:0]          name_char;
        logic                entry_valid;
        logic                trunc;
    } result_t;

endpackage

>>> sv/kmm_parser.sv
module kmm_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     byte_en,
    input  logic                     eol,
    input  logic [7:0]               ch,
    input  logic [kmm_pkg::POS_W-1:0] rd_pos,
    output logic [7:0]               buf_q,
    output kmm_pkg::line_info_t      info
);
    import kmm_pkg::*;

    localparam logic [1:0] SUB_START = 2'd0;
    localparam logic [1:0] SUB_INT   = 2'd1;
    localparam logic [1:0] SUB_FRAC  = 2'd2;
    localparam logic [1:0] SUB_DONE  = 2'd3;
    localparam logic [10:0] CAP      = 11'd999;

    logic [7:0]       line_buf [NAME_BYTES];
    logic             phase_reg, phase_next;
    logic [POS_W-1:0] len_reg, len_next;
    logic             trunc_reg, trunc_next;
    logic [9:0]       acc_reg, acc_next;
    logic             seen_reg, seen_next;
    logic             neg_reg, neg_next;
    logic [1:0]       sub_reg, sub_next;
    logic             buf_we;
    logic             digit, blank, sign, go_int;
    logic [3:0]       d;
    logic [10:0]      acc10, int_sum, frac_sum;
    logic [9:0]       int_val, frac_val;

    assign digit = (ch >= 8'h30) && (ch <= 8'h39);
    assign d     = ch[3:0];
    assign blank = (ch == 8'h20) || (ch == 8'h09);
    assign sign  = (ch == 8'h2D) || (ch == 8'h2B);

    // scale integer part by ten, clamp once it cannot stay below the cap
    assign acc10    = (acc_reg > 10'd99) ? CAP : ({1'b0, acc_reg} << 3) + ({1'b0, acc_reg} << 1);
    assign int_sum  = acc10 + ({7'd0, d} << 3) + ({7'd0, d} << 1);
    assign int_val  = (int_sum > CAP) ? CAP[9:0] : int_sum[9:0];
    assign frac_sum = {1'b0, acc_reg} + {7'd0, d};
    assign frac_val = (frac_sum > CAP) ? CAP[9:0] : frac_sum[9:0];
    assign go_int   = (sub_reg == SUB_INT) || ((sub_reg == SUB_START) && !blank && !sign);

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        trunc_next = trunc_reg;
        acc_next   = acc_reg;
        seen_next  = seen_reg;
        neg_next   = neg_reg;
        sub_next   = sub_reg;
        buf_we     = 1'b0;
        if (eol)
        begin
            phase_next = 1'b0;
            len_next   = '0;
            trunc_next = 1'b0;
            acc_next   = '0;
            seen_next  = 1'b0;
            neg_next   = 1'b0;
            sub_next   = SUB_START;
        end
        else if (byte_en && !phase_reg)
        begin
            if (ch == SEP_CHAR)
                phase_next = 1'b1;
            else if (len_reg != POS_W'(NAME_BYTES - 1))
            begin
                buf_we   = 1'b1;
                len_next = len_reg + 1'b1;
            end
            else
                trunc_next = 1'b1;
        end
        else if (byte_en)
        begin
            seen_next = 1'b1;
            if (sub_reg == SUB_START && sign)
            begin
                neg_next = (ch == 8'h2D);
                sub_next = SUB_INT;
            end
            else if (go_int)
            begin
                if (digit)
                begin
                    acc_next = int_val;
                    sub_next = SUB_INT;
                end
                else if (ch == 8'h2E)
                    sub_next = SUB_FRAC;
                else
                    sub_next = SUB_DONE;
            end
            else if (sub_reg == SUB_FRAC)
            begin
                if (digit)
                    acc_next = frac_val;
                sub_next = SUB_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
            len_reg   <= '0;
            trunc_reg <= 1'b0;
            acc_reg   <= '0;
            seen_reg  <= 1'b0;
            neg_reg   <= 1'b0;
            sub_reg   <= SUB_START;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            trunc_reg <= trunc_next;
            acc_reg   <= acc_next;
            seen_reg  <= seen_next;
            neg_reg   <= neg_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
            line_buf[len_reg] <= ch;
        buf_q <= line_buf[rd_pos];
    end

    assign info.phase = phase_reg;
    assign info.len   = len_reg;
    assign info.trunc = trunc_reg;
    assign info.seen  = seen_reg;
    assign info.temp  = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});

endmodule

>>> sv/kmm_store.sv
module kmm_store (
    input  logic                        clk,
    input  logic [kmm_pkg::SLOT_W-1:0]  slot,
    input  logic [kmm_pkg::POS_W-1:0]   pos,
    input  logic                        ent_we,
    input  kmm_pkg::entry_t             ent_wdata,
    input  logic                        name_we,
    input  logic [7:0]                  name_wdata,
    output kmm_pkg::entry_t             ent_q,
    output logic [7:0]                  name_q
);
    import kmm_pkg::*;

    entry_t     ent_mem  [TABLE_DEPTH];
    logic [7:0] name_mem [TABLE_DEPTH * NAME_BYTES];

    logic [NADDR_W-1:0] name_addr;

    assign name_addr = {slot, pos};

    always_ff @(posedge clk)
    begin
        if (ent_we)
            ent_mem[slot] <= ent_wdata;
        ent_q <= ent_mem[slot];
    end

    always_ff @(posedge clk)
    begin
        if (name_we)
            name_mem[name_addr] <= name_wdata;
        name_q <= name_mem[name_addr];
    end

endmodule

>>> sv/kmm_alu.sv
module kmm_alu (
    input  kmm_pkg::entry_t    cur,
    input  logic signed [10:0] temp,
    output kmm_pkg::entry_t    upd
);
    import kmm_pkg::*;

    logic signed [48:0] sum_wide;

    assign sum_wide = {cur.sum[47], cur.sum} + 49'(temp);

    always_comb
    begin
        upd     = cur;
        upd.min = (temp < cur.min) ? temp : cur.min;
        upd.max = (temp > cur.max) ? temp : cur.max;
        // clamp to the 48-bit signed range on overflow
        if (sum_wide[48] != sum_wide[47])
            upd.sum = sum_wide[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        else
            upd.sum = sum_wide[47:0];
        upd.count = (&cur.count) ? cur.count : cur.count + 1'b1;
    end

endmodule

>>> sv/keyed_min_max_sum_count_aggregator_unit.sv
// Keyed min/max/sum/count aggregator. Feed text words (tuser 0) one byte at a time in
// lines "name;temperature\n"; each newline yields one result word: record applied
// (with the entry's updated stats) or record dropped. Read words (tuser 1 stats,
// tuser 2 name byte) return one entry. Ordinary text bytes are taken while idle and give
// no result. A newline walks the table with one shared byte comparator over a
// single-port name memory: each entry visited has its length checked and, on a match,
// its name compared byte by byte; a name not found is copied byte by byte into a new
// entry, and the result is then registered (a line dropped at once skips the walk).
// A read holds the input through ST_RD_ISSUE, ST_RD_DONE and ST_EMIT after it is
// accepted. Input is not ready while a line or read is being worked on; a finished
// result sits in the output register and does not block the next text byte, but a
// further result waits for it to be taken.
module keyed_min_max_sum_count_aggregator_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // text_byte[7:0], slot_sel[15:8], name_pos[21:16], zero
    input  logic [1:0]   s_tuser,   // op[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot[7:0], is_new[8], min_tenths[19:9], max_tenths[30:20], sum_tenths[78:31],
    // sample_count[110:79], name_char[118:111], entry_valid[119], name_truncated[120],
    // entries_used[129:121], zero
    output logic [135:0] m_tdata,
    output logic [1:0]   m_tuser    // kind[1:0]
);
    import kmm_pkg::*;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_SCAN     = 4'd1;
    localparam logic [3:0] ST_LEN_CHK  = 4'd2;
    localparam logic [3:0] ST_BYTE_RD  = 4'd3;
    localparam logic [3:0] ST_BYTE_CHK = 4'd4;
    localparam logic [3:0] ST_UPD      = 4'd5;
    localparam logic [3:0] ST_COPY_RD  = 4'd6;
    localparam logic [3:0] ST_COPY_WR  = 4'd7;
    localparam logic [3:0] ST_RD_ISSUE = 4'd8;
    localparam logic [3:0] ST_RD_DONE  = 4'd9;
    localparam logic [3:0] ST_EMIT     = 4'd10;

    logic [3:0]         state_reg, state_next;
    logic [FILL_W-1:0]  slot_reg, slot_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [POS_W-1:0]   line_len_reg, line_len_next;
    logic               trunc_reg, trunc_next;
    logic signed [10:0] temp_reg, temp_next;
    logic [1:0]         op_reg, op_next;
    result_t            res_reg, res_next;
    result_t            out_reg;
    logic [8:0]         used_reg;
    logic               m_tvalid_reg;

    logic       accept, is_text, is_eol, emit_go;
    logic [7:0] ch;
    line_info_t info;
    logic [7:0] buf_q, name_q;
    entry_t     ent_q, ent_upd, ent_wdata;
    logic       ent_we, name_we;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign ch       = s_tdata[7:0];
    assign is_text  = accept && (s_tuser == OP_TEXT);
    assign is_eol   = is_text && (ch == EOL_CHAR);
    assign emit_go  = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    kmm_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_en (is_text && (ch != EOL_CHAR)),
        .eol     (is_eol),
        .ch      (ch),
        .rd_pos  (pos_reg),
        .buf_q   (buf_q),
        .info    (info)
    );

    kmm_store u_store (
        .clk        (clk),
        .slot       (slot_reg[SLOT_W-1:0]),
        .pos        (pos_reg),
        .ent_we     (ent_we),
        .ent_wdata  (ent_wdata),
        .name_we    (name_we),
        .name_wdata (buf_q),
        .ent_q      (ent_q),
        .name_q     (name_q)
    );

    kmm_alu u_alu (
        .cur  (ent_q),
        .temp (temp_reg),
        .upd  (ent_upd)
    );

    always_comb
    begin
        state_next    = state_reg;
        slot_next     = slot_reg;
        pos_next      = pos_reg;
        fill_next     = fill_reg;
        line_len_next = line_len_reg;
        trunc_next    = trunc_reg;
        temp_next     = temp_reg;
        op_next       = op_reg;
        res_next      = res_reg;
        ent_we        = 1'b0;
        name_we       = 1'b0;
        ent_wdata     = ent_upd;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_eol)
                begin
                    line_len_next = info.len;
                    trunc_next    = info.trunc;
                    temp_next     = info.temp;
                    slot_next     = '0;
                    // drop lines without a separator, a name or a temperature field
                    if (!info.phase || (info.len == '0) || !info.seen)
                    begin
                        res_next        = '0;
                        res_next.kind   = KIND_DROPPED;
                        res_next.trunc  = info.trunc;
                        state_next      = ST_EMIT;
                    end
                    else
                        state_next = ST_SCAN;
                end
                else if (accept && ((s_tuser == OP_STATS) || (s_tuser == OP_NAME)))
                begin
                    op_next    = s_tuser;
                    slot_next  = {1'b0, s_tdata[15:8]};
                    pos_next   = s_tdata[21:16];
                    state_next = ST_RD_ISSUE;
                end
            end
            ST_SCAN:
            begin
                if (slot_reg == fill_reg)
                begin
                    if (fill_reg == FILL_W'(TABLE_DEPTH))
                    begin
                        res_next        = '0;
                        res_next.kind   = KIND_DROPPED;
                        res_next.is_new = 1'b1;
                        res_next.trunc  = trunc_reg;
                        state_next      = ST_EMIT;
                    end
                    else
                    begin
                        pos_next   = '0;
                        state_next = ST_COPY_RD;
                    end
                end
                else
                    state_next = ST_LEN_CHK;
            end
            ST_LEN_CHK:
            begin
                if (ent_q.len == line_len_reg)
                begin
                    pos_next   = '0;
                    state_next = ST_BYTE_RD;
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_BYTE_RD:
                state_next = ST_BYTE_CHK;
            ST_BYTE_CHK:
            begin
                if (name_q != buf_q)
                begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = ST_SCAN;
                end
                else if (pos_reg == line_len_reg - 1'b1)
                    state_next = ST_UPD;
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_BYTE_RD;
                end
            end
            ST_UPD:
            begin
                ent_we               = 1'b1;
                res_next             = '0;
                res_next.kind        = KIND_APPLIED;
                res_next.slot        = slot_reg[7:0];
                res_next.min         = ent_upd.min;
                res_next.max         = ent_upd.max;
                res_next.sum         = ent_upd.sum;
                res_next.count       = ent_upd.count;
                res_next.entry_valid = 1'b1;
                res_next.trunc       = trunc_reg;
                state_next           = ST_EMIT;
            end
            ST_COPY_RD:
                state_next = ST_COPY_WR;
            ST_COPY_WR:
            begin
                name_we = 1'b1;
                if (pos_reg == line_len_reg - 1'b1)
                begin
                    ent_we               = 1'b1;
                    ent_wdata.len        = line_len_reg;
                    ent_wdata.min        = temp_reg;
                    ent_wdata.max        = temp_reg;
                    ent_wdata.sum        = 48'(temp_reg);
                    ent_wdata.count      = 32'd1;
                    fill_next            = fill_reg + 1'b1;
                    res_next             = '0;
                    res_next.kind        = KIND_APPLIED;
                    res_next.slot        = slot_reg[7:0];
                    res_next.is_new      = 1'b1;
                    res_next.min         = temp_reg;
                    res_next.max         = temp_reg;
                    res_next.sum         = 48'(temp_reg);
                    res_next.count       = 32'd1;
                    res_next.entry_valid = 1'b1;
                    res_next.trunc       = trunc_reg;
                    state_next           = ST_EMIT;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_COPY_RD;
                end
            end
            ST_RD_ISSUE:
                state_next = ST_RD_DONE;
            ST_RD_DONE:
            begin
                res_next      = '0;
                res_next.kind = (op_reg == OP_STATS) ? KIND_STATS : KIND_NAME;
                res_next.slot = slot_reg[7:0];
                if (slot_reg < fill_reg)
                begin
                    res_next.entry_valid = 1'b1;
                    if (op_reg == OP_STATS)
                    begin
                        res_next.min   = ent_q.min;
                        res_next.max   = ent_q.max;
                        res_next.sum   = ent_q.sum;
                        res_next.count = ent_q.count;
                    end
                    else if (pos_reg < ent_q.len)
                        res_next.name_char = name_q;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_go)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (emit_go)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        slot_reg     <= slot_next;
        pos_reg      <= pos_next;
        line_len_reg <= line_len_next;
        trunc_reg    <= trunc_next;
        temp_reg     <= temp_next;
        op_reg       <= op_next;
        res_reg      <= res_next;
        if (emit_go)
        begin
            out_reg  <= res_reg;
            used_reg <= 9'(fill_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {6'd0, used_reg, out_reg.trunc, out_reg.entry_valid, out_reg.name_char,
                       out_reg.count, out_reg.sum, out_reg.max, out_reg.min, out_reg.is_new,
                       out_reg.slot};

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg != $past(fill_reg)) |-> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("fill count moved by more than one");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEN_CHK || state_reg == ST_BYTE_CHK) |-> (slot_reg < fill_reg))
        else $error("scan past filled entries");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> m_tvalid)
        else $error("result lost on emit");

endmodule
